// File: src/hsl_saturation_lightness_adjust_assert.svh
// ----------------------------------------------------------------------------
// HSL adjuster assertion macros
// Immediate-consequence and next-cycle property helpers clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef HSL_SATURATION_LIGHTNESS_ADJUST_ASSERT_SVH
`define HSL_SATURATION_LIGHTNESS_ADJUST_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define HSLA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hsla assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define HSLA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hsla assertion failed");

`endif

// File: src/hsla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL adjuster package
// Shared types, constants and helpers of the RGB/HSL saturation-lightness
// adjuster.
// ----------------------------------------------------------------------------
package hsla_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned Q_W        = 17;
  localparam int unsigned DIV_W      = 11;
  localparam int unsigned DIV_LANES  = 2;
  localparam int unsigned DIV_STAGES = 8;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned AMT_W      = 18;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam int unsigned LANE_S = 0;
  localparam int unsigned LANE_H = 1;

  localparam logic [Q_W-1:0] Q_ONE  = 17'd65536;
  localparam logic [Q_W-1:0] Q_HALF = 17'd32768;

  localparam logic [17:0] T3_TURN  = 18'd196608;
  localparam logic [17:0] T3_ONE   = 18'd65536;
  localparam logic [17:0] T3_SIXTH = 18'd32768;
  localparam logic [17:0] T3_HALF  = 18'd98304;
  localparam logic [17:0] T3_TWO3  = 18'd131072;

  localparam logic REG_ADJUST_TARGET = 1'b0;
  localparam logic REG_ADJUST_AMOUNT = 1'b1;

  localparam logic TARGET_SAT   = 1'b0;
  localparam logic TARGET_LIGHT = 1'b1;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_FLAT,
    SEG_FALL,
    SEG_LOW
  } seg_e;

  typedef struct packed {
    logic                    target;
    logic signed [AMT_W-1:0] amount;
  } cfg_t;

  typedef struct packed {
    logic [15:0]    h;
    logic [Q_W-1:0] s;
    logic [Q_W-1:0] l;
  } hsl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  function automatic logic [Q_W-1:0] clamp_one(input logic signed [20:0] v);
    logic [Q_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({4'b0, Q_ONE})) begin
      r = Q_ONE;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/hsla_rgb2hsl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL stages
// Extremes, numerators and divisors, then a pipelined radix-2 restoring
// divider (two quotient bits per stage, three in the first) for saturation and hue; lightness
// by reciprocal multiplication at the last stage.
// ----------------------------------------------------------------------------
module hsla_rgb2hsl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [hsla_pkg::CH_W-1:0] red_i,
  input  logic [hsla_pkg::CH_W-1:0] green_i,
  input  logic [hsla_pkg::CH_W-1:0] blue_i,
  output logic                      valid_o,
  output hsla_pkg::hsl_t            hsl_o
);
  import hsla_pkg::*;

  localparam logic [24:0] L_RECIP = 25'd16843010;

  logic [CH_W-1:0]  mx, mn, d;
  logic [CH_W:0]    sum;
  logic [CH_W-1:0]  den;
  logic [DIV_W-1:0] num, d6;
  logic             ach;

  logic [DIV_LANES-1:0][DIV_W-1:0] a_d, b_d;

  logic                            dv_q  [DIV_STAGES+1];
  logic                            ach_q [DIV_STAGES+1];
  logic [CH_W:0]                   sum_q [DIV_STAGES+1];
  logic [DIV_LANES-1:0][DIV_W-1:0] rem_q [DIV_STAGES+1];
  logic [DIV_LANES-1:0][DIV_W-1:0] bq_q  [DIV_STAGES+1];
  logic [DIV_LANES-1:0][Q_W-1:0]   quo_q [DIV_STAGES+1];

  logic [23:0] ln_n;
  logic [48:0] lp;

  logic valid_q;
  hsl_t hsl_d, hsl_q;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    sum = {1'b0, mx} + {1'b0, mn};
    d   = mx - mn;
    ach = (d == '0);
    d6  = ({3'b0, d} << 2) + ({3'b0, d} << 1);
    den = (sum > 9'd255) ? 8'(9'd510 - sum) : sum[CH_W-1:0];
    if (mx == red_i) begin
      num = {3'b0, green_i} - {3'b0, blue_i} + ((green_i < blue_i) ? d6 : 11'd0);
    end else if (mx == green_i) begin
      num = {3'b0, blue_i} - {3'b0, red_i} + ({3'b0, d} << 1);
    end else begin
      num = {3'b0, red_i} - {3'b0, green_i} + ({3'b0, d} << 2);
    end
    a_d[LANE_S] = {3'b0, d};
    b_d[LANE_S] = ach ? 11'd1 : {3'b0, den};
    a_d[LANE_H] = num;
    b_d[LANE_H] = ach ? 11'd1 : d6;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ach_q[0] <= ach;
      sum_q[0] <= sum;
      rem_q[0] <= a_d;
      bq_q[0]  <= b_d;
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    localparam int BIT_TOP = 15 - 2 * (k - 1);
    logic [DIV_LANES-1:0][DIV_W-1:0] rem_d;
    logic [DIV_LANES-1:0][Q_W-1:0]   quo_d;

    always_comb begin
      logic [DIV_W:0] t;
      logic [15:0]    hb;
      t  = '0;
      hb = '0;
      for (int ln = 0; ln < DIV_LANES; ln++) begin
        rem_d[ln] = rem_q[k-1][ln];
        quo_d[ln] = quo_q[k-1][ln];
        hb        = {6'b0, bq_q[k-1][ln][DIV_W-1:1]};
        if (k == 1) begin
          if (rem_d[ln] >= bq_q[k-1][ln]) begin
            quo_d[ln][Q_W-1] = 1'b1;
            rem_d[ln]        = rem_d[ln] - bq_q[k-1][ln];
          end
        end
        for (int j = 0; j < 2; j++) begin
          t = {rem_d[ln], hb[4'(BIT_TOP - j)]};
          if (t >= {1'b0, bq_q[k-1][ln]}) begin
            quo_d[ln][5'(BIT_TOP - j)] = 1'b1;
            t = t - {1'b0, bq_q[k-1][ln]};
          end
          rem_d[ln] = t[DIV_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en_i) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ach_q[k] <= ach_q[k-1];
        sum_q[k] <= sum_q[k-1];
        rem_q[k] <= rem_d;
        bq_q[k]  <= bq_q[k-1];
        quo_q[k] <= quo_d;
      end
    end
  end

  always_comb begin
    ln_n    = {sum_q[DIV_STAGES], 15'b0} + 24'd127;
    lp      = 49'(ln_n) * 49'(L_RECIP);
    hsl_d.l = lp[48:32];
    hsl_d.s = ach_q[DIV_STAGES] ? '0 : quo_q[DIV_STAGES][LANE_S];
    hsl_d.h = ach_q[DIV_STAGES] ? '0 : quo_q[DIV_STAGES][LANE_H][15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= dv_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hsl_q <= hsl_d;
    end
  end

  assign valid_o = valid_q;
  assign hsl_o   = hsl_q;

endmodule

// File: src/hsla_hsl2rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB stages
// Adjust and clamp, lightness-saturation product, q/p computation, hue segment
// select, channel products, channel value and byte rounding, one register stage each.
// ----------------------------------------------------------------------------
module hsla_hsl2rgb (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  hsla_pkg::cfg_t cfg_i,
  input  logic           valid_i,
  input  hsla_pkg::hsl_t hsl_i,
  output logic           valid_o,
  output hsla_pkg::rgb_t rgb_o
);
  import hsla_pkg::*;

  localparam int unsigned NSTG = 7;

  logic v_q [NSTG];

  // adjust
  logic signed [19:0] adj_sum;
  logic [Q_W-1:0]     s1_d, l1_d, s1_q, l1_q;
  logic [15:0]        h1_q;

  // product
  logic [17:0]        op2;
  logic               lo2_d, lo2_q;
  logic [34:0]        prod2_d, prod2_q;
  logic [Q_W-1:0]     s2_q, l2_q;
  logic [15:0]        h2_q;

  // q, p, diff
  logic [19:0]        rnd3;
  logic signed [20:0] qv3;
  logic [Q_W-1:0]     q3, p3_d, diff3_d, p3_q, diff3_q;
  logic [15:0]        h3_q;

  // segments
  logic [17:0]             th3;
  logic [NUM_CH-1:0][17:0] t4;
  seg_e                    seg4_d [NUM_CH];
  seg_e                    seg4_q [NUM_CH];
  logic [NUM_CH-1:0][15:0] fac4_d, fac4_q;
  logic [Q_W-1:0]          p4_q, diff4_q;

  // channel products
  logic [NUM_CH-1:0][32:0] prod5_d, prod5_q;
  seg_e                    seg5_q [NUM_CH];
  logic [Q_W-1:0]          p5_q, diff5_q;

  // channel values
  logic [NUM_CH-1:0][Q_W-1:0] v6_d, v6_q;

  // bytes
  logic [NUM_CH-1:0][CH_W-1:0] byte7_d;
  rgb_t                        rgb7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < NSTG; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_comb begin
    s1_d = hsl_i.s;
    l1_d = hsl_i.l;
    if (cfg_i.target == TARGET_SAT) begin
      adj_sum = $signed({3'b0, hsl_i.s}) + 20'(cfg_i.amount);
      s1_d    = clamp_one(21'(adj_sum));
    end else begin
      adj_sum = $signed({3'b0, hsl_i.l}) + 20'(cfg_i.amount);
      l1_d    = clamp_one(21'(adj_sum));
    end
  end

  always_comb begin
    lo2_d   = (l1_q < Q_HALF);
    op2     = lo2_d ? ({1'b0, Q_ONE} + {1'b0, s1_q}) : {1'b0, s1_q};
    prod2_d = 35'(l1_q) * 35'(op2);
  end

  always_comb begin
    rnd3 = 20'((36'(prod2_q) + 36'd32768) >> 16);
    if (lo2_q) begin
      qv3 = $signed({1'b0, rnd3});
    end else begin
      qv3 = $signed({4'b0, l2_q}) + $signed({4'b0, s2_q}) - $signed({1'b0, rnd3});
    end
    q3      = clamp_one(qv3);
    p3_d    = clamp_one($signed({3'b0, l2_q, 1'b0}) - $signed({4'b0, q3}));
    diff3_d = (q3 >= p3_d) ? (q3 - p3_d) : '0;
  end

  always_comb begin
    logic [18:0] tr;
    th3 = {1'b0, h3_q, 1'b0} + {2'b0, h3_q};
    tr  = {1'b0, th3} + {1'b0, T3_ONE};
    t4[0] = (tr > {1'b0, T3_TURN}) ? 18'(tr - {1'b0, T3_TURN}) : tr[17:0];
    t4[1] = th3;
    t4[2] = (th3 < T3_ONE) ? (th3 + T3_TWO3) : (th3 - T3_ONE);
    for (int c = 0; c < NUM_CH; c++) begin
      if (t4[c] < T3_SIXTH) begin
        seg4_d[c] = SEG_RISE;
        fac4_d[c] = t4[c][15:0];
      end else if (t4[c] < T3_HALF) begin
        seg4_d[c] = SEG_FLAT;
        fac4_d[c] = '0;
      end else if (t4[c] < T3_TWO3) begin
        seg4_d[c] = SEG_FALL;
        fac4_d[c] = 16'(T3_TWO3 - t4[c]);
      end else begin
        seg4_d[c] = SEG_LOW;
        fac4_d[c] = '0;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod5_d[c] = 33'(diff4_q) * 33'(fac4_q[c]);
    end
  end

  always_comb begin
    logic [18:0] vs;
    vs = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      case (seg5_q[c])
        SEG_RISE, SEG_FALL: vs = {2'b0, p5_q} + 19'((34'(prod5_q[c]) + 34'd16384) >> 15);
        SEG_FLAT:           vs = {2'b0, p5_q} + {2'b0, diff5_q};
        SEG_LOW:            vs = {2'b0, p5_q};
        default:            vs = {2'b0, p5_q};
      endcase
      v6_d[c] = (vs > {2'b0, Q_ONE}) ? Q_ONE : vs[Q_W-1:0];
    end
  end

  always_comb begin
    logic [24:0] sc;
    logic [8:0]  r9;
    sc = '0;
    r9 = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      sc = ({8'b0, v6_q[c]} << 8) - {8'b0, v6_q[c]} + 25'd32768;
      r9 = sc[24:16];
      byte7_d[c] = r9[8] ? 8'd255 : r9[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h1_q    <= hsl_i.h;
      s1_q    <= s1_d;
      l1_q    <= l1_d;
      lo2_q   <= lo2_d;
      prod2_q <= prod2_d;
      s2_q    <= s1_q;
      l2_q    <= l1_q;
      h2_q    <= h1_q;
      p3_q    <= p3_d;
      diff3_q <= diff3_d;
      h3_q    <= h2_q;
      fac4_q  <= fac4_d;
      p4_q    <= p3_q;
      diff4_q <= diff3_q;
      prod5_q <= prod5_d;
      p5_q    <= p4_q;
      diff5_q <= diff4_q;
      v6_q    <= v6_d;
      rgb7_q  <= {byte7_d[0], byte7_d[1], byte7_d[2]};
      for (int c = 0; c < NUM_CH; c++) begin
        seg4_q[c] <= seg4_d[c];
        seg5_q[c] <= seg4_q[c];
      end
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign rgb_o   = rgb7_q;

endmodule

// File: src/hsl_saturation_lightness_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL saturation / lightness adjuster
// RGB pixel to HSL, signed delta on saturation or lightness, back to RGB.
//
// Channel   Direction   Handshake               Payload
// in        input       in_valid_i/in_ready_o   in_red_i, in_green_i, in_blue_i
// out       output      out_valid_o/out_ready_i out_red_o, out_green_o, out_blue_o
// cfg       input       cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
// One pixel per cycle while in_ready_o is high; out_valid_o rises once a pixel
// has passed the 17-stage datapath (8 divider stages) and the output buffer write.
// Reset clears both registers to zero and empties the pipeline.
// The pipeline freezes only while the two-entry output buffer is full and
// out_ready_i is low; in_ready_o drops in that case.
// ----------------------------------------------------------------------------
`include "hsl_saturation_lightness_adjust_assert.svh"

module hsl_saturation_lightness_adjust (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [hsla_pkg::CH_W-1:0]    in_red_i,
  input  logic [hsla_pkg::CH_W-1:0]    in_green_i,
  input  logic [hsla_pkg::CH_W-1:0]    in_blue_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [hsla_pkg::CH_W-1:0]    out_red_o,
  output logic [hsla_pkg::CH_W-1:0]    out_green_o,
  output logic [hsla_pkg::CH_W-1:0]    out_blue_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [hsla_pkg::AMT_W-1:0]   cfg_wdata_i
);
  import hsla_pkg::*;

  cfg_t cfg_q;
  logic advance, push, pop;
  logic hv, pv;
  hsl_t hsl;
  rgb_t prgb;

  rgb_t       buf_q [FIFO_DEPTH];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ADJUST_TARGET: cfg_q.target <= cfg_wdata_i[0];
        REG_ADJUST_AMOUNT: cfg_q.amount <= $signed(cfg_wdata_i);
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  assign advance    = (cnt_q != 2'(FIFO_DEPTH)) || out_ready_i;
  assign in_ready_o = advance;
  assign push       = pv && advance;
  assign pop        = out_valid_o && out_ready_i;

  hsla_rgb2hsl u_rgb2hsl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_valid_i),
    .red_i   (in_red_i),
    .green_i (in_green_i),
    .blue_i  (in_blue_i),
    .valid_o (hv),
    .hsl_o   (hsl)
  );

  hsla_hsl2rgb u_hsl2rgb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .cfg_i   (cfg_q),
    .valid_i (hv),
    .hsl_i   (hsl),
    .valid_o (pv),
    .rgb_o   (prgb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= prgb;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_red_o   = buf_q[rptr_q].red;
  assign out_green_o = buf_q[rptr_q].green;
  assign out_blue_o  = buf_q[rptr_q].blue;

  `HSLA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= 2'(FIFO_DEPTH))
  `HSLA_ASSERT_IMP(a_stall_full, !in_ready_o, cnt_q == 2'(FIFO_DEPTH))
  `HSLA_ASSERT_NXT(a_cnt_inc, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
  `HSLA_ASSERT_NXT(a_cnt_dec, pop && !push, cnt_q == $past(cnt_q) - 2'd1)

endmodule

// File: tb/sv/tb_hsl_saturation_lightness_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL saturation / lightness adjuster testbench
// Drives RGB pixels through the valid/ready input, predicts each adjusted
// pixel with an integer HSL model, and compares results in order. Phases
// sweep target and delta settings, including both extremes and out-of-range
// deltas, with random idling on both sides, full-rate phases and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_hsl_saturation_lightness_adjust;
  import hsla_pkg::*;

  localparam int ONE     = 65536;
  localparam int TURN    = 196608;
  localparam int LATENCY = 18;
  localparam int LIMIT   = 400000;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] in_red_i = '0, in_green_i = '0, in_blue_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] out_red_o, out_green_o, out_blue_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = REG_ADJUST_TARGET;
  logic [AMT_W-1:0] cfg_wdata_i = '0;

  pix_t pending_pixels[$];
  pix_t expected_pixels[$];
  logic mdl_target;
  longint mdl_amount;
  int send_idle_pct, recv_idle_pct, holdoff_cycles;
  int errors, mismatches, n_in, n_out, cycles;

  hsl_saturation_lightness_adjust dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic longint clamp_q(longint v);
    return v < 0 ? 0 : (v > ONE ? ONE : v);
  endfunction

  function automatic longint rdiv(longint a, longint b);
    return (a + b / 2) / b;
  endfunction

  function automatic longint hue_channel(longint p, longint diff, longint t3);
    longint v;
    if (t3 < 0) t3 += TURN;
    if (t3 > TURN) t3 -= TURN;
    if (t3 < 32768) v = p + ((diff * t3 + 16384) >>> 15);
    else if (t3 < 98304) v = p + diff;
    else if (t3 < 131072) v = p + ((diff * (131072 - t3) + 16384) >>> 15);
    else v = p;
    return clamp_q(v);
  endfunction

  function automatic logic [7:0] q_to_byte(longint v);
    longint r;
    r = (clamp_q(v) * 255 + 32768) >>> 16;
    return r > 255 ? 8'd255 : r[7:0];
  endfunction

  function automatic pix_t adjust_pixel(pix_t px);
    longint r, g, b, mx, mn, sum, h, s, l, d, den, num, q, p, diff;
    pix_t o;
    r = px.r; g = px.g; b = px.b;
    mx = r > g ? (r > b ? r : b) : (g > b ? g : b);
    mn = r < g ? (r < b ? r : b) : (g < b ? g : b);
    sum = mx + mn;
    h = 0; s = 0;
    l = rdiv(sum * ONE, 510);
    if (mx != mn) begin
      d = mx - mn;
      den = sum > 255 ? 510 - sum : sum;
      s = rdiv(d * ONE, den);
      if (mx == r) num = (g - b) + (g < b ? 6 * d : 0);
      else if (mx == g) num = (b - r) + 2 * d;
      else num = (r - g) + 4 * d;
      h = rdiv(num * ONE, 6 * d) & 64'hFFFF;
    end
    if (mdl_target == TARGET_SAT) s = clamp_q(s + mdl_amount);
    else l = clamp_q(l + mdl_amount);
    if (s == 0) begin
      o.r = q_to_byte(l); o.g = o.r; o.b = o.r;
    end else begin
      if (l < 32768) q = (l * (ONE + s) + 32768) >>> 16;
      else q = l + s - ((l * s + 32768) >>> 16);
      q = clamp_q(q);
      p = clamp_q(2 * l - q);
      diff = q - p;
      if (diff < 0) diff = 0;
      o.r = q_to_byte(hue_channel(p, diff, 3 * h + ONE));
      o.g = q_to_byte(hue_channel(p, diff, 3 * h));
      o.b = q_to_byte(hue_channel(p, diff, 3 * h - ONE));
    end
    return o;
  endfunction

  task automatic write_reg(logic idx, logic [AMT_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ADJUST_TARGET) mdl_target = val[0];
    else mdl_amount = $signed(val);
  endtask

  task automatic drain_pipeline();
    wait (pending_pixels.size() == 0 && !in_valid_i);
    wait (expected_pixels.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pix_t px;
    px = '{r, g, b};
    pending_pixels.push_back(px);
  endtask

  task automatic queue_directed();
    queue_pixel(0, 0, 0);       queue_pixel(255, 255, 255);
    queue_pixel(128, 128, 128); queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);     queue_pixel(0, 0, 255);
    queue_pixel(255, 255, 0);   queue_pixel(0, 255, 255);
    queue_pixel(255, 0, 255);   queue_pixel(200, 10, 100);
    queue_pixel(10, 20, 200);   queue_pixel(127, 128, 0);
    queue_pixel(1, 0, 0);       queue_pixel(254, 255, 255);
    queue_pixel(170, 85, 85);   queue_pixel(85, 170, 255);
  endtask

  task automatic queue_random(int n);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        1: begin
          logic [7:0] v;
          v = 8'($urandom);
          queue_pixel(v, v + 8'($urandom_range(0, 2)), v);
        end
        2: queue_pixel(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                       8'($urandom_range(0, 40)));
        default: queue_pixel(8'($urandom_range(215, 255)), 8'($urandom_range(215, 255)),
                             8'($urandom_range(215, 255)));
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) n_in <= n_in + 1;
        if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          pix_t px;
          px = pending_pixels.pop_front();
          expected_pixels.push_back(adjust_pixel(px));
          in_valid_i <= 1'b1;
          in_red_i <= px.r;
          in_green_i <= px.g;
          in_blue_i <= px.b;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        pix_t exp_px;
        n_out <= n_out + 1;
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("unexpected pixel %0d %0d %0d", out_red_o, out_green_o, out_blue_o);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (exp_px != {out_red_o, out_green_o, out_blue_o}) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d got %0d %0d %0d (target %0d amount %0d)",
                       exp_px.r, exp_px.g, exp_px.b, out_red_o, out_green_o, out_blue_o,
                       mdl_target, mdl_amount);
          end
        end
      end
      if (holdoff_cycles > 0) begin
        holdoff_cycles <= holdoff_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= $urandom_range(0, 99) >= recv_idle_pct;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels pending", cycles, expected_pixels.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    mdl_target = TARGET_SAT;
    mdl_amount = 0;
    errors = 0; mismatches = 0; n_in = 0; n_out = 0; cycles = 0;
    send_idle_pct = 16; recv_idle_pct = 65; holdoff_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    drain_pipeline();
    for (int ph = 0; ph < 12; ph++) begin
      logic [AMT_W-1:0] amt;
      case (ph % 6)
        0: amt = 18'sd65536;
        1: amt = -18'sd65536;
        2: amt = 18'h1FFFF;
        3: amt = 18'h20000;
        default: amt = 18'($urandom_range(0, 131072) - 65536);
      endcase
      if (ph == 4) begin
        send_idle_pct = 65; recv_idle_pct = 16;
      end else if (ph == 8) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      write_reg(REG_ADJUST_TARGET, ph[0] ? TARGET_LIGHT : TARGET_SAT);
      write_reg(REG_ADJUST_AMOUNT, amt);
      if (ph == 9) holdoff_cycles = 200;
      queue_directed();
      queue_random(112);
      drain_pipeline();
    end
    $display("covered %0d pixels in, %0d out over 12 target/delta settings", n_in, n_out);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d errors, %0d mismatches", errors, mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
